@@ design/color_palette_index_builder_macros.svh @@
// assertion macros for the palette index builder checker
`ifndef COLOR_PALETTE_INDEX_BUILDER_MACROS_SVH
`define COLOR_PALETTE_INDEX_BUILDER_MACROS_SVH

// same-cycle implication
`define CPIB_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CPIB_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/cpib_pkg.sv @@
package cpib_pkg;

    localparam int PALETTE_ENTRIES_DEF = 255;
    localparam int INDEX_W = 8;
    localparam int COLOR_W = 16;
    localparam int CHAN_W = 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               image_start;
    } cpib_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } cpib_state_t;

endpackage

@@ design/cpib_front.sv @@
module cpib_front (
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [cpib_pkg::CHAN_W-1:0]       s_red,
    input  logic [cpib_pkg::CHAN_W-1:0]       s_green,
    input  logic [cpib_pkg::CHAN_W-1:0]       s_blue,
    input  logic [cpib_pkg::CHAN_W-1:0]       s_alpha,
    input  logic                              s_image_start,
    input  logic                              q_full,
    output logic                              q_push,
    output cpib_pkg::cpib_item_t              q_item
);
    import cpib_pkg::*;

    // rgba5551: top five bits of each color channel, top bit of alpha
    function automatic logic [COLOR_W-1:0] pack5551(
        input logic [CHAN_W-1:0] r,
        input logic [CHAN_W-1:0] g,
        input logic [CHAN_W-1:0] b,
        input logic [CHAN_W-1:0] a
    );
        return {r[7:3], g[7:3], b[7:3], a[7]};
    endfunction

    assign s_ready = !q_full;
    assign q_push = s_valid && !q_full;

    always_comb begin
        q_item.color = pack5551(s_red, s_green, s_blue, s_alpha);
        q_item.image_start = s_image_start;
    end

endmodule

@@ design/cpib_queue.sv @@
module cpib_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  cpib_pkg::cpib_item_t  push_item,
    output logic                  full,
    input  logic                  pop,
    output logic                  not_empty,
    output cpib_pkg::cpib_item_t  pop_item
);
    import cpib_pkg::*;

    localparam logic [QUEUE_PTR_W:0] FULL_FILL = (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);

    cpib_item_t             entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W:0]   fill_reg;
    logic [QUEUE_PTR_W:0]   fill_next;

    assign full = (fill_reg == FULL_FILL);
    assign not_empty = (fill_reg != '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ design/cpib_back.sv @@
module cpib_back #(
    parameter int PALETTE_ENTRIES = cpib_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  cpib_pkg::cpib_item_t          q_item,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [cpib_pkg::INDEX_W-1:0]  m_palette_index,
    output logic [cpib_pkg::COLOR_W-1:0]  m_packed_color,
    output logic                          m_new_entry,
    output logic                          m_overflow
);
    import cpib_pkg::*;

    localparam int ADDR_W = $clog2(PALETTE_ENTRIES);
    localparam logic [INDEX_W-1:0] LAST_COUNT = INDEX_W'(PALETTE_ENTRIES);

    logic [COLOR_W-1:0] mem [PALETTE_ENTRIES];

    cpib_state_t        state_reg, state_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic [INDEX_W-1:0] count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic [INDEX_W-1:0] rd_addr_reg, rd_addr_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [INDEX_W-1:0] cmp_addr_reg, cmp_addr_next;
    logic [INDEX_W-1:0] res_index_reg, res_index_next;
    logic               res_new_reg, res_new_next;
    logic [COLOR_W-1:0] rdata_reg;
    logic               m_valid_reg;
    logic [INDEX_W-1:0] m_index_reg;
    logic [COLOR_W-1:0] m_color_reg;
    logic               m_new_reg;
    logic               m_ovf_reg;

    logic match;
    logic issue;
    logic rd_en;
    logic wr_en;
    logic out_load;

    assign match = cmp_valid_reg && (rdata_reg == color_reg);
    assign issue = (rd_addr_reg != count_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (match || !issue) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        q_pop = 1'b0;
        rd_en = 1'b0;
        wr_en = 1'b0;
        out_load = 1'b0;
        color_next = color_reg;
        count_next = count_reg;
        ovf_next = ovf_reg;
        rd_addr_next = rd_addr_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_addr_next = cmp_addr_reg;
        res_index_next = res_index_reg;
        res_new_next = res_new_reg;
        unique case (state_reg)
            ST_IDLE: begin
                q_pop = q_valid;
                if (q_valid) begin
                    color_next = q_item.color;
                    rd_addr_next = '0;
                    cmp_valid_next = 1'b0;
                    if (q_item.image_start) begin
                        count_next = '0;
                        ovf_next = 1'b0;
                    end
                end
            end
            ST_SCAN: begin
                rd_en = issue && !match;
                cmp_valid_next = rd_en;
                cmp_addr_next = rd_addr_reg;
                rd_addr_next = rd_addr_reg + {{(INDEX_W-1){1'b0}}, rd_en};
                if (match) begin
                    res_index_next = cmp_addr_reg;
                    res_new_next = 1'b0;
                end else if (!issue) begin
                    if (count_reg != LAST_COUNT) begin
                        wr_en = 1'b1;
                        res_index_next = count_reg;
                        res_new_next = 1'b1;
                        count_next = count_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                        res_index_next = '0;
                        res_new_next = 1'b0;
                    end
                end
            end
            ST_DONE: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ovf_reg <= 1'b0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg <= ovf_next;
            cmp_valid_reg <= cmp_valid_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        color_reg <= color_next;
        rd_addr_reg <= rd_addr_next;
        cmp_addr_reg <= cmp_addr_next;
        res_index_reg <= res_index_next;
        res_new_reg <= res_new_next;
        if (out_load) begin
            m_index_reg <= res_index_reg;
            m_color_reg <= color_reg;
            m_new_reg <= res_new_reg;
            m_ovf_reg <= ovf_reg;
        end
    end

    // palette memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[ADDR_W-1:0]] <= color_reg;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr_reg[ADDR_W-1:0]];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_palette_index = m_index_reg;
    assign m_packed_color = m_color_reg;
    assign m_new_entry = m_new_reg;
    assign m_overflow = m_ovf_reg;

endmodule

@@ design/color_palette_index_builder.sv @@
// Converts RGBA8888 pixels to RGBA5551 and maps each color to a slot of a palette built
// per image (up to PALETTE_ENTRIES slots). A hit returns the slot; a miss appends the color
// and flags new_entry; a miss with a full palette sets overflow, sticky until a pixel with
// image_start. The search reads one stored color per cycle from a single-port palette
// memory. A two-entry queue lets new pixels be accepted while a search runs, and a result
// register holds the last result while the next search proceeds.
module color_palette_index_builder #(
    parameter int PALETTE_ENTRIES = cpib_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [cpib_pkg::CHAN_W-1:0]   s_red,
    input  logic [cpib_pkg::CHAN_W-1:0]   s_green,
    input  logic [cpib_pkg::CHAN_W-1:0]   s_blue,
    input  logic [cpib_pkg::CHAN_W-1:0]   s_alpha,
    input  logic                          s_image_start,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [cpib_pkg::INDEX_W-1:0]  m_palette_index,
    output logic [cpib_pkg::COLOR_W-1:0]  m_packed_color,
    output logic                          m_new_entry,
    output logic                          m_overflow
);
    import cpib_pkg::*;

    logic       q_full;
    logic       q_push;
    logic       q_pop;
    logic       q_not_empty;
    cpib_item_t push_item;
    cpib_item_t pop_item;

    cpib_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .s_alpha       (s_alpha),
        .s_image_start (s_image_start),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (push_item)
    );

    cpib_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (pop_item)
    );

    cpib_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_not_empty),
        .q_item          (pop_item),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_palette_index (m_palette_index),
        .m_packed_color  (m_packed_color),
        .m_new_entry     (m_new_entry),
        .m_overflow      (m_overflow)
    );

endmodule

@@ design/cpib_checker.sv @@
`include "color_palette_index_builder_macros.svh"

module cpib_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [cpib_pkg::CHAN_W-1:0]   s_red,
    input logic [cpib_pkg::CHAN_W-1:0]   s_green,
    input logic [cpib_pkg::CHAN_W-1:0]   s_blue,
    input logic [cpib_pkg::CHAN_W-1:0]   s_alpha,
    input logic                          s_image_start,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [cpib_pkg::INDEX_W-1:0]  m_palette_index,
    input logic [cpib_pkg::COLOR_W-1:0]  m_packed_color,
    input logic                          m_new_entry,
    input logic                          m_overflow
);
    import cpib_pkg::*;

    // a full palette cannot take a new entry in the same image
    `CPIB_ASSERT_SAME(a_new_not_ovf, aclk, aresetn, m_valid && m_new_entry, !m_overflow, "new entry with overflow set")

    // the all-ones index, one past the last slot, is never produced
    `CPIB_ASSERT_SAME(a_index_range, aclk, aresetn, m_valid, m_palette_index != 8'hFF, "palette index out of range")

    // stalled result holds
    `CPIB_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_packed_color) && $stable(m_palette_index), "result changed while stalled")

    // stalled request holds
    `CPIB_ASSERT_NEXT(a_in_hold, aclk, aresetn, s_valid && !s_ready, s_valid && $stable({s_red, s_green, s_blue, s_alpha, s_image_start}), "request changed while stalled")

endmodule

bind color_palette_index_builder cpib_checker u_cpib_checker (.*);
